// ===== rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int HEAP_BYTES   = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int ADDR_W       = 12;
    localparam int SIZE_W       = 12;
    localparam int WIDE_W       = ADDR_W + 2;

    localparam logic [SIZE_W-1:0] SZ_HDR      = SIZE_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] SZ_SPLIT    = SIZE_W'(HEADER_BYTES + 1);
    localparam logic [SIZE_W-1:0] SZ_INIT     = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [WIDE_W-1:0] WIDE_HEAP   = WIDE_W'(HEAP_BYTES);

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE     = 3'd1;
    localparam logic [2:0] ST_NO_SPACE     = 3'd2;
    localparam logic [2:0] ST_NOT_BLOCK    = 3'd3;
    localparam logic [2:0] ST_ALREADY_FREE = 3'd4;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic              marked;
        logic              used;
        logic [SIZE_W-1:0] size;
    } hdr_entry_t;

    localparam int ENTRY_W = $bits(hdr_entry_t);

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        hdr_entry_t        wdata;
    } ram_req_t;

    typedef struct packed {
        logic              valid;
        logic [2:0]        status;
        logic [ADDR_W-1:0] offset;
    } result_t;

endpackage

// ===== rtl/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 14
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [DATA_BITS-1:0] wdata,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ===== rtl/ffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer that walks the header chain and updates it in the header RAM.
// ----------------------------------------------------------------------------
module ffa_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       req_type,
    input  logic [ffa_pkg::SIZE_W-1:0] req_size,
    input  logic [ffa_pkg::ADDR_W-1:0] free_offset,
    input  ffa_pkg::hdr_entry_t        rdata,
    output ffa_pkg::ram_req_t          ram,
    output ffa_pkg::result_t           fin,
    output logic                       busy
);
    import ffa_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_AWALK  = 11'b000_0000_0100,
        S_ASPLIT = 11'b000_0000_1000,
        S_FCHK   = 11'b000_0001_0000,
        S_FWALK  = 11'b000_0010_0000,
        S_FNXT   = 11'b000_0100_0000,
        S_FW1    = 11'b000_1000_0000,
        S_FW2    = 11'b001_0000_0000,
        S_FW3    = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [SIZE_W-1:0] want_reg, want_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] hdr_reg, hdr_next;
    hdr_entry_t        hent_reg, hent_next;
    logic [ADDR_W-1:0] prev_reg, prev_next;
    hdr_entry_t        pent_reg, pent_next;
    logic              hasp_reg, hasp_next;
    logic [ADDR_W-1:0] nxt_reg, nxt_next;
    logic              nxtok_reg, nxtok_next;
    logic              nfree_reg, nfree_next;
    logic [SIZE_W-1:0] msize_reg, msize_next;
    logic [2:0]        st_reg, st_next;
    logic [ADDR_W-1:0] offs_reg, offs_next;

    logic [WIDE_W-1:0] npos;
    logic [WIDE_W-1:0] nxt_wide;
    logic              pmerge;

    assign npos     = WIDE_W'(pos_reg) + WIDE_W'(SZ_HDR) + WIDE_W'(rdata.size);
    assign nxt_wide = WIDE_W'(hdr_reg) + WIDE_W'(SZ_HDR) + WIDE_W'(rdata.size);
    assign pmerge   = hasp_reg && !pent_reg.used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg  <= want_next;
        pos_reg   <= pos_next;
        hdr_reg   <= hdr_next;
        hent_reg  <= hent_next;
        prev_reg  <= prev_next;
        pent_reg  <= pent_next;
        hasp_reg  <= hasp_next;
        nxt_reg   <= nxt_next;
        nxtok_reg <= nxtok_next;
        nfree_reg <= nfree_next;
        msize_reg <= msize_next;
        st_reg    <= st_next;
        offs_reg  <= offs_next;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        want_next  = want_reg;
        pos_next   = pos_reg;
        hdr_next   = hdr_reg;
        hent_next  = hent_reg;
        prev_next  = prev_reg;
        pent_next  = pent_reg;
        hasp_next  = hasp_reg;
        nxt_next   = nxt_reg;
        nxtok_next = nxtok_reg;
        nfree_next = nfree_reg;
        msize_next = msize_reg;
        st_next    = st_reg;
        offs_next  = offs_reg;
        ram        = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram.en   = 1'b1;
                ram.we   = 1'b1;
                ram.addr = clr_reg;
                if (clr_reg == '0)
                begin
                    ram.wdata = '{marked: 1'b1, used: 1'b0, size: SZ_INIT};
                end
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    want_next = req_size;
                    offs_next = '0;
                    if (req_type == REQ_ALLOC)
                    begin
                        if (req_size == '0)
                        begin
                            st_next    = ST_BAD_SIZE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            pos_next   = '0;
                            ram.en     = 1'b1;
                            state_next = S_AWALK;
                        end
                    end
                    else
                    begin
                        if (free_offset < ADDR_W'(HEADER_BYTES))
                        begin
                            st_next    = ST_NOT_BLOCK;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            hdr_next   = free_offset - ADDR_W'(HEADER_BYTES);
                            ram.en     = 1'b1;
                            ram.addr   = free_offset - ADDR_W'(HEADER_BYTES);
                            state_next = S_FCHK;
                        end
                    end
                end
            end
            S_AWALK:
            begin
                if (!rdata.used && want_reg <= rdata.size)
                begin
                    ram.en    = 1'b1;
                    ram.we    = 1'b1;
                    ram.addr  = pos_reg;
                    st_next   = ST_OK;
                    offs_next = pos_reg + ADDR_W'(HEADER_BYTES);
                    hent_next = rdata;
                    if (rdata.size - want_reg >= SZ_SPLIT)
                    begin
                        ram.wdata  = '{marked: 1'b1, used: 1'b1, size: want_reg};
                        state_next = S_ASPLIT;
                    end
                    else
                    begin
                        ram.wdata  = '{marked: 1'b1, used: 1'b1, size: rdata.size};
                        state_next = S_DONE;
                    end
                end
                else if (npos >= WIDE_HEAP)
                begin
                    st_next    = ST_NO_SPACE;
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next = npos[ADDR_W-1:0];
                    ram.en   = 1'b1;
                    ram.addr = npos[ADDR_W-1:0];
                end
            end
            S_ASPLIT:
            begin
                ram.en     = 1'b1;
                ram.we     = 1'b1;
                ram.addr   = pos_reg + ADDR_W'(HEADER_BYTES) + want_reg;
                ram.wdata  = '{marked: 1'b1, used: 1'b0,
                               size: hent_reg.size - want_reg - SZ_HDR};
                state_next = S_DONE;
            end
            S_FCHK:
            begin
                hent_next  = rdata;
                hasp_next  = 1'b0;
                nxt_next   = nxt_wide[ADDR_W-1:0];
                nxtok_next = nxt_wide < WIDE_HEAP;
                if (!rdata.marked)
                begin
                    st_next    = ST_NOT_BLOCK;
                    state_next = S_DONE;
                end
                else if (!rdata.used)
                begin
                    st_next    = ST_ALREADY_FREE;
                    state_next = S_DONE;
                end
                else if (hdr_reg == '0)
                begin
                    // The first block has no previous neighbour.
                    if (nxt_wide < WIDE_HEAP)
                    begin
                        ram.en     = 1'b1;
                        ram.addr   = nxt_wide[ADDR_W-1:0];
                        state_next = S_FNXT;
                    end
                    else
                    begin
                        nfree_next = 1'b0;
                        msize_next = rdata.size;
                        state_next = S_FW1;
                    end
                end
                else
                begin
                    pos_next   = '0;
                    ram.en     = 1'b1;
                    state_next = S_FWALK;
                end
            end
            S_FWALK:
            begin
                prev_next = pos_reg;
                pent_next = rdata;
                hasp_next = 1'b1;
                if (npos < WIDE_W'(hdr_reg))
                begin
                    pos_next = npos[ADDR_W-1:0];
                    ram.en   = 1'b1;
                    ram.addr = npos[ADDR_W-1:0];
                end
                else if (npos == WIDE_W'(hdr_reg))
                begin
                    if (nxtok_reg)
                    begin
                        ram.en     = 1'b1;
                        ram.addr   = nxt_reg;
                        state_next = S_FNXT;
                    end
                    else
                    begin
                        nfree_next = 1'b0;
                        msize_next = hent_reg.size;
                        state_next = S_FW1;
                    end
                end
                else
                begin
                    st_next    = ST_NOT_BLOCK;
                    state_next = S_DONE;
                end
            end
            S_FNXT:
            begin
                nfree_next = !rdata.used;
                msize_next = rdata.used ? hent_reg.size
                                        : hent_reg.size + SZ_HDR + rdata.size;
                state_next = S_FW1;
            end
            S_FW1:
            begin
                ram.en = 1'b1;
                ram.we = 1'b1;
                if (pmerge)
                begin
                    ram.addr  = prev_reg;
                    ram.wdata = '{marked: 1'b1, used: 1'b0,
                                  size: pent_reg.size + SZ_HDR + msize_reg};
                end
                else
                begin
                    ram.addr  = hdr_reg;
                    ram.wdata = '{marked: 1'b1, used: 1'b0, size: msize_reg};
                end
                state_next = S_FW2;
            end
            S_FW2:
            begin
                ram.en     = pmerge;
                ram.we     = 1'b1;
                ram.addr   = hdr_reg;
                state_next = S_FW3;
            end
            S_FW3:
            begin
                ram.en     = nfree_reg;
                ram.we     = 1'b1;
                ram.addr   = nxt_reg;
                st_next    = ST_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy       = state_reg != S_IDLE;
    assign fin.valid  = state_reg == S_DONE;
    assign fin.status = st_reg;
    assign fin.offset = (st_reg == ST_OK) ? offs_reg : '0;

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with block splitting and neighbour coalescing.
// ----------------------------------------------------------------------------
// A request word is taken at a rising edge where start is high and busy is
// low: req_type selects allocate or free, req_size gives the payload bytes
// for an allocate and free_offset the payload offset for a free.
// Exactly one result word follows per request, shown on status and
// payload_offset for a single cycle and marked by done. The receiver cannot
// hold it off, and none is needed, since busy stays high until the cycle in
// which the result is shown.
// Block headers live in a single-port header RAM of one entry per byte
// offset, with a registered read port. A nonzero allocate, and a free of
// a used block other than the first, walks the header chain from offset
// zero, one header per cycle.
// After reset the header RAM is swept once, one entry a cycle, leaving
// one free block over the whole heap; busy is high for the whole sweep.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       req_type,
    input  logic [ffa_pkg::SIZE_W-1:0] req_size,
    input  logic [ffa_pkg::ADDR_W-1:0] free_offset,
    output logic                       done,
    output logic [2:0]                 status,
    output logic [ffa_pkg::ADDR_W-1:0] payload_offset
);
    import ffa_pkg::*;

    ram_req_t          ram;
    result_t           fin;
    logic [ENTRY_W-1:0] rdata_raw;
    hdr_entry_t        rdata;
    logic              done_reg;
    logic [2:0]        status_reg;
    logic [ADDR_W-1:0] offset_reg;

    assign rdata = hdr_entry_t'(rdata_raw);

    ffa_ram #(
        .ADDR_BITS(ADDR_W),
        .DATA_BITS(ENTRY_W)
    ) u_ram (
        .clk  (clk),
        .en   (ram.en),
        .we   (ram.we),
        .addr (ram.addr),
        .wdata(ram.wdata),
        .rdata(rdata_raw)
    );

    ffa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req_type   (req_type),
        .req_size   (req_size),
        .free_offset(free_offset),
        .rdata      (rdata),
        .ram        (ram),
        .fin        (fin),
        .busy       (busy)
    );

    // The result word is registered so that it is shown for one cycle only.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= fin.status;
        offset_reg <= fin.offset;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign payload_offset = offset_reg;

endmodule

// ===== rtl/ffa_checker.sv =====
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks of the allocator's request and result words.
// ----------------------------------------------------------------------------
module ffa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic [11:0] payload_offset
);
    import ffa_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in flight");

    a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> payload_offset == '0)
        else $error("non-zero offset on a failed request");

endmodule

bind first_fit_heap_allocator ffa_checker u_ffa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .payload_offset(payload_offset)
);

// ===== test/first_fit_heap_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Self-checking bench for the first-fit heap allocator.
// ----------------------------------------------------------------------------
// Request words are driven on the falling edge and result words sampled on
// the rising edge. A behavioural heap model predicts every result word, and
// a small scoreboard compares them in order. Directed requests cover the
// rejection cases, and random traffic is mostly allocate/free pairs on live
// blocks with some noise, under several idling phases.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffa_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    // One expected result word.
    typedef struct {
        logic [2:0]        status;
        logic [ADDR_W-1:0] offset;
    } alloc_answer_t;

    // Scoreboard: holds expected words in order and checks arriving ones.
    class answer_board;
        alloc_answer_t pending[$];
        int            errors;

        function void note(alloc_answer_t a);
            pending.push_back(a);
        endfunction

        function void check(logic [2:0] st, logic [ADDR_W-1:0] off);
            alloc_answer_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: status %0d offset %0d", st, off);
                return;
            end
            e = pending.pop_front();
            if (e.status !== st || e.offset !== off)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected status %0d offset %0d, got %0d %0d",
                             e.status, e.offset, st, off);
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              req_type = REQ_ALLOC;
    logic [SIZE_W-1:0] req_size = '0;
    logic [ADDR_W-1:0] free_offset = '0;
    logic              done;
    logic [2:0]        status;
    logic [ADDR_W-1:0] payload_offset;

    answer_board board = new();
    int          cycles = 0;
    int          idle_pct = 0;

    // The heap model: mark, in-use bit and payload size per byte offset.
    bit          hp_mark[HEAP_BYTES];
    bit          hp_used[HEAP_BYTES];
    int unsigned hp_size[HEAP_BYTES];
    // Payload offsets handed out and not yet freed.
    int          live[$];

    always #10 clk = ~clk;

    first_fit_heap_allocator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .req_size(req_size), .free_offset(free_offset),
        .done(done), .status(status), .payload_offset(payload_offset)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
            board.check(status, payload_offset);
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int unsigned block_end(int unsigned p);
        return p + HEADER_BYTES + hp_size[p];
    endfunction

    function automatic alloc_answer_t predict_alloc(int unsigned want);
        alloc_answer_t r;
        int unsigned   p, old;
        r.status = ST_NO_SPACE;
        r.offset = '0;
        if (want == 0)
        begin
            r.status = ST_BAD_SIZE;
            return r;
        end
        p = 0;
        while (p < HEAP_BYTES)
        begin
            if (!hp_used[p] && want <= hp_size[p])
            begin
                old = hp_size[p];
                if (old - want >= HEADER_BYTES + 1)
                begin
                    hp_size[p] = want;
                    hp_mark[p + HEADER_BYTES + want] = 1'b1;
                    hp_used[p + HEADER_BYTES + want] = 1'b0;
                    hp_size[p + HEADER_BYTES + want] = old - want - HEADER_BYTES;
                end
                hp_used[p] = 1'b1;
                hp_mark[p] = 1'b1;
                r.status = ST_OK;
                r.offset = ADDR_W'(p + HEADER_BYTES);
                live.push_back(p + HEADER_BYTES);
                return r;
            end
            p = block_end(p);
        end
        return r;
    endfunction

    function automatic alloc_answer_t predict_free(int unsigned payload);
        alloc_answer_t r;
        int unsigned   h, p, prev, nx;
        bit            has_prev;
        r.offset = '0;
        r.status = ST_NOT_BLOCK;
        p = 0;
        prev = 0;
        has_prev = 1'b0;
        if (payload < HEADER_BYTES)
            return r;
        h = payload - HEADER_BYTES;
        if (h >= HEAP_BYTES || !hp_mark[h])
            return r;
        if (!hp_used[h])
        begin
            r.status = ST_ALREADY_FREE;
            return r;
        end
        while (p < h)
        begin
            prev = p;
            has_prev = 1'b1;
            p = block_end(p);
        end
        if (p != h)
            return r;
        hp_used[h] = 1'b0;
        nx = block_end(h);
        if (nx < HEAP_BYTES && !hp_used[nx])
        begin
            hp_size[h] += HEADER_BYTES + hp_size[nx];
            hp_mark[nx] = 1'b0;
            hp_size[nx] = 0;
        end
        if (has_prev && !hp_used[prev])
        begin
            hp_size[prev] += HEADER_BYTES + hp_size[h];
            hp_mark[h] = 1'b0;
            hp_size[h] = 0;
        end
        foreach (live[i])
            if (live[i] == payload)
            begin
                live.delete(i);
                break;
            end
        r.status = ST_OK;
        return r;
    endfunction

    // Drive one request word and wait for it to be taken. Start is left
    // high afterwards; an idle cycle or drain() lowers it.
    task automatic send_request(logic kind, int unsigned sz, int unsigned off);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        req_type    <= kind;
        req_size    <= SIZE_W'(sz);
        free_offset <= ADDR_W'(off);
        start       <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (kind == REQ_ALLOC)
            board.note(predict_alloc(sz & 12'hFFF));
        else
            board.note(predict_free(off & 12'hFFF));
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    // Random request: mostly frees of live blocks and small allocates.
    task automatic random_request();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 40)
            send_request(REQ_ALLOC, $urandom_range(1, 64), $urandom);
        else if (k < 45)
            send_request(REQ_ALLOC, $urandom_range(0, 4095), $urandom);
        else if (k < 85 && live.size() > 0)
            send_request(REQ_FREE, $urandom,
                         live[$urandom_range(live.size() - 1)]);
        else if (k < 92)
            send_request(REQ_FREE, $urandom, $urandom_range(0, 4095));
        else
            send_request(REQ_FREE, $urandom, $urandom_range(0, 15));
    endtask

    initial
    begin
        hp_mark[0] = 1'b1;
        hp_size[0] = HEAP_BYTES - HEADER_BYTES;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: rejections, exact fit, double free, merges.
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_ALLOC, 4095, 4095);
        send_request(REQ_ALLOC, 4088, 0);
        send_request(REQ_ALLOC, 1, 0);
        send_request(REQ_FREE, 0, 8);
        send_request(REQ_FREE, 0, 8);
        send_request(REQ_FREE, 0, 0);
        send_request(REQ_FREE, 0, 7);
        send_request(REQ_FREE, 0, 4095);
        send_request(REQ_ALLOC, 100, 0);
        send_request(REQ_ALLOC, 200, 0);
        send_request(REQ_ALLOC, 300, 0);
        send_request(REQ_FREE, 0, 120);
        send_request(REQ_FREE, 0, 13);
        send_request(REQ_FREE, 0, 8);
        send_request(REQ_FREE, 0, 328);
        send_request(REQ_ALLOC, 4079, 0);
        send_request(REQ_ALLOC, 4080, 0);
        send_request(REQ_FREE, 0, 8);
        send_request(REQ_ALLOC, 2048, 0);
        send_request(REQ_ALLOC, 2040, 0);
        send_request(REQ_FREE, 0, 2064);
        send_request(REQ_FREE, 0, 8);

        // The sender holds off until every word is back.
        drain();

        // Random phases: sender idle in 54 of 100 in the second, 31 of 100 in the fourth, else no idling.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 54 : (ph == 3) ? 31 : 0;
            repeat (470) random_request();
        end

        drain();
        repeat (5000)
        begin
            if (cycles >= CYCLE_LIMIT - 1)
                break;
            @(negedge clk);
        end
        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
